[src/bdlp_pkg.sv]
// ============================================================================
// bdlp_pkg
// Shared codes, reset values and types for the button debounce and
// long-press detector.
// ============================================================================
`timescale 1ns / 1ps

package bdlp_pkg;

    // Press phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_DEBOUNCE = 3'd1;
    localparam logic [2:0] PH_HELD     = 3'd2;
    localparam logic [2:0] PH_LONG     = 3'd3;
    localparam logic [2:0] PH_RELEASE  = 3'd4;

    // Press event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHORT = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;

    // Register indexes on the configuration port
    localparam logic REG_DEBOUNCE   = 1'b0;
    localparam logic REG_LONG_PRESS = 1'b1;

    // Register reset values
    localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd10;
    localparam logic [15:0] LONG_PRESS_MS_RST = 16'd1000;

    // Configuration handed to the press machine
    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
    } t_cfg;

    // Status returned by the press machine for the current sample
    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] press_event;
    } t_status;

endpackage

[src/bdlp_fsm.sv]
// ============================================================================
// bdlp_fsm
// Five-phase press machine: holds phase, last change time and press start
// time, and classifies a debounced release as a short or long press.
// ============================================================================
`timescale 1ns / 1ps

module bdlp_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_pin_level,
    input  logic [31:0]      i_now_ms,
    input  bdlp_pkg::t_cfg   i_cfg,
    output bdlp_pkg::t_status o_status
);
    import bdlp_pkg::*;

    logic [2:0]  r_phase;
    logic [31:0] r_last_change;
    logic [31:0] r_press_start;
    logic [2:0]  n_phase;
    logic [31:0] n_last_change;
    logic [31:0] n_press_start;
    logic [1:0]  w_event;

    logic        w_pressed;
    logic [31:0] w_since_change;
    logic [31:0] w_since_start;
    logic        w_debounced;
    logic        w_is_long;

    // Wrapping elapsed times and the two threshold compares
    assign w_pressed      = ~i_pin_level;
    assign w_since_change = i_now_ms - r_last_change;
    assign w_since_start  = i_now_ms - r_press_start;
    assign w_debounced    = w_since_change >= {16'd0, i_cfg.debounce_ms};
    assign w_is_long      = w_since_start >= {16'd0, i_cfg.long_press_ms};

    // Advance the phase for the current sample
    always_comb begin
        n_phase       = r_phase;
        n_last_change = r_last_change;
        n_press_start = r_press_start;
        w_event       = EV_NONE;
        case (r_phase)
            PH_DEBOUNCE: begin
                if (w_pressed) begin
                    if (w_debounced) begin
                        n_phase       = PH_HELD;
                        n_press_start = i_now_ms;
                    end
                end else begin
                    n_phase       = PH_IDLE;
                    n_last_change = i_now_ms;
                end
            end
            PH_HELD: begin
                if (w_pressed) begin
                    if (w_is_long) begin
                        n_phase = PH_LONG;
                    end
                end else begin
                    n_phase       = PH_RELEASE;
                    n_last_change = i_now_ms;
                end
            end
            PH_LONG: begin
                if (!w_pressed) begin
                    n_phase       = PH_RELEASE;
                    n_last_change = i_now_ms;
                end
            end
            PH_RELEASE: begin
                if (w_pressed) begin
                    // bounce on release: resume the hold
                    n_last_change = i_now_ms;
                    n_phase       = w_is_long ? PH_LONG : PH_HELD;
                end else if (w_debounced) begin
                    n_phase = PH_IDLE;
                    w_event = w_is_long ? EV_LONG : EV_SHORT;
                end
            end
            default: begin
                // idle and unused codes
                if (w_pressed) begin
                    n_phase       = PH_DEBOUNCE;
                    n_last_change = i_now_ms;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    // Hold state between samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_last_change <= 32'd0;
            r_press_start <= 32'd0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_last_change <= n_last_change;
            r_press_start <= n_press_start;
        end
    end

    assign o_status.phase       = r_phase;
    assign o_status.press_event = w_event;

endmodule

[src/button_debounce_long_press_core.sv]
// ============================================================================
// button_debounce_long_press_core
// Debounced active-low button with short and long press reporting.
// ============================================================================
// The block takes one sample word per clock (pin level and millisecond
// timestamp) and returns exactly one result word per sample, in order:
// press_event is 0 for no event, 1 when a short press has just been
// released and debounced, 2 for a long press. A sample passes through an
// input register and then a result register before its result is offered;
// samples may be accepted every cycle, and the input stalls only while a
// result waits and the input register is full.
// debounce_ms and long_press_ms sit at byte addresses 0 and 4 of the APB
// port and should be written while no samples are in flight.
`timescale 1ns / 1ps

module button_debounce_long_press_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_pin_level,
    input  logic [31:0] i_now_ms,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_press_event,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bdlp_pkg::*;

    t_cfg        r_cfg;
    logic        r_s1_valid;
    logic        r_s1_pin;
    logic [31:0] r_s1_now;
    logic        r_out_valid;
    logic [1:0]  r_out_event;
    logic        w_adv;
    logic        w_cfg_wr;
    t_status     w_status;

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_MS_RST;
            r_cfg.long_press_ms <= LONG_PRESS_MS_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_DEBOUNCE) begin
                r_cfg.debounce_ms <= pwdata[15:0];
            end else begin
                r_cfg.long_press_ms <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DEBOUNCE:   prdata = {16'd0, r_cfg.debounce_ms};
            REG_LONG_PRESS: prdata = {16'd0, r_cfg.long_press_ms};
            default:        prdata = 32'd0;
        endcase
    end

    // Advance the input register when the result register can take a word
    assign w_adv      = r_s1_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_s1_valid | w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_pin <= i_pin_level;
            r_s1_now <= i_now_ms;
        end
    end

    // Press machine works on the registered sample
    bdlp_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_adv),
        .i_pin_level (r_s1_pin),
        .i_now_ms    (r_s1_now),
        .i_cfg       (r_cfg),
        .o_status    (w_status)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_event <= w_status.press_event;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_press_event = r_out_event;

`ifndef ASSERT_OFF
    // a completed press always returns the machine to idle
    a_event_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_status.press_event != EV_NONE) |=> (w_status.phase == PH_IDLE))
        else $error("press event without return to idle");

    // a waiting result word is never dropped
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result word lost while stalled");

    // input stalls only when both stages are full and the output is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without cause");

    // the unused event code never reaches the output
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_press_event == EV_NONE || o_press_event == EV_SHORT
                         || o_press_event == EV_LONG))
        else $error("invalid press event code");
`endif

endmodule

[dv/tb_button_debounce_long_press_core.sv]
// ============================================================================
// tb_button_debounce_long_press_core
// Self-checking bench for the debounced button short/long press detector.
// ============================================================================
// A press-machine predictor runs beside the block. Every sample word that the
// block accepts advances the predictor, and the predicted press event is
// queued. Each result word is checked against the oldest queued event. The
// stimulus has two parts. A directed part covers bounces, exact thresholds,
// timestamp wrap and zero settings. A random part follows with press cycles
// and noise under several register settings. The sender idles in bursts and
// the receiver stalls on its own pattern.
`timescale 1ns / 1ps

module tb_button_debounce_long_press_core;
    import bdlp_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;

    // Predictor of the press machine plus the queue of pending press events
    class press_scoreboard;
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [2:0]  phase;
        logic [31:0] last_change_ms;
        logic [31:0] press_start_ms;
        logic [1:0]  event_q[$];
        int unsigned n_checked;
        int unsigned n_short;
        int unsigned n_long;
        int unsigned n_errors;

        function new();
            debounce_ms    = DEBOUNCE_MS_RST;
            long_press_ms  = LONG_PRESS_MS_RST;
            phase          = PH_IDLE;
            last_change_ms = '0;
            press_start_ms = '0;
            n_checked      = 0;
            n_short        = 0;
            n_long         = 0;
            n_errors       = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == REG_DEBOUNCE) begin
                debounce_ms = val;
            end else begin
                long_press_ms = val;
            end
        endfunction

        // Advance the press machine by one accepted sample
        function void note_sample(logic pin_level, logic [31:0] now_ms);
            logic        pressed;
            logic [31:0] since_change;
            logic [31:0] held_for;
            logic [1:0]  press_event;
            pressed      = ~pin_level;
            since_change = now_ms - last_change_ms;
            held_for     = now_ms - press_start_ms;
            press_event  = EV_NONE;
            case (phase)
                PH_DEBOUNCE: begin
                    if (pressed) begin
                        if (since_change >= {16'd0, debounce_ms}) begin
                            phase          = PH_HELD;
                            press_start_ms = now_ms;
                        end
                    end else begin
                        phase          = PH_IDLE;
                        last_change_ms = now_ms;
                    end
                end
                PH_HELD: begin
                    if (pressed) begin
                        if (held_for >= {16'd0, long_press_ms}) phase = PH_LONG;
                    end else begin
                        phase          = PH_RELEASE;
                        last_change_ms = now_ms;
                    end
                end
                PH_LONG: begin
                    if (!pressed) begin
                        phase          = PH_RELEASE;
                        last_change_ms = now_ms;
                    end
                end
                PH_RELEASE: begin
                    if (pressed) begin
                        // release bounce: resume the hold
                        last_change_ms = now_ms;
                        phase = (held_for < {16'd0, long_press_ms}) ? PH_HELD : PH_LONG;
                    end else if (since_change >= {16'd0, debounce_ms}) begin
                        phase       = PH_IDLE;
                        press_event = (held_for < {16'd0, long_press_ms}) ? EV_SHORT
                                                                           : EV_LONG;
                    end
                end
                default: begin
                    if (pressed) begin
                        phase          = PH_DEBOUNCE;
                        last_change_ms = now_ms;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
            endcase
            event_q.push_back(press_event);
        endfunction

        // Compare one result word with the oldest pending event
        function void check_result(logic [1:0] press_event);
            logic [1:0] want;
            if (event_q.size() == 0) begin
                $error("press_event %0d arrived with nothing expected", press_event);
                n_errors++;
                return;
            end
            want = event_q.pop_front();
            n_checked++;
            if (press_event !== want) begin
                $error("press_event mismatch: expected %0d, actual %0d", want, press_event);
                n_errors++;
            end else if (press_event == EV_SHORT) begin
                n_short++;
            end else if (press_event == EV_LONG) begin
                n_long++;
            end
        endfunction

        function int pending();
            return event_q.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic        i_pin_level = 1'b1;
    logic [31:0] i_now_ms    = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_press_event;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    press_scoreboard press_sb = new();

    int unsigned cycle_count = 0;
    int unsigned n_sent      = 0;
    int unsigned n_settings  = 0;
    int unsigned burst_left  = 0;
    int unsigned reg_errors  = 0;
    int unsigned ready_mode  = 0;
    logic [31:0] clock_ms    = '0;

    button_debounce_long_press_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pin_level   (i_pin_level),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_press_event (o_press_event),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** button_debounce_long_press_core: FAILED **");
            $finish;
        end
    end

    // Check result words and stall the receiver on a changing pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) press_sb.check_result(o_press_event);
        if (cycle_count % 48 == 0) ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 1) == 0);
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (cycle_count[2] == 1'b0);
        endcase
    end

    // Offer one sample word and hold it until accepted
    task automatic send_sample(input logic pin_level, input logic [31:0] now_ms);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid  <= 1'b1;
        i_pin_level <= pin_level;
        i_now_ms    <= now_ms;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        press_sb.note_sample(pin_level, now_ms);
        n_sent++;
        burst_left--;
    endtask

    // Advance the timestamp by a random step and send
    task automatic send_after(input logic pin_level, input int unsigned max_step);
        clock_ms = clock_ms + $urandom_range(0, max_step);
        send_sample(pin_level, clock_ms);
    endtask

    // Stop sending and wait until every pending result word is back
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (press_sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One APB transfer, followed by an idle bus
    task automatic apb_access(input logic wr, input logic idx, input logic [15:0] val,
                              output logic [31:0] rd_data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd_data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write both registers while idle and read them back
    task automatic set_cfg(input logic [15:0] debounce_ms, input logic [15:0] long_press_ms);
        logic [31:0] rd_data;
        drain();
        apb_access(1'b1, REG_DEBOUNCE, debounce_ms, rd_data);
        press_sb.set_reg(REG_DEBOUNCE, debounce_ms);
        apb_access(1'b1, REG_LONG_PRESS, long_press_ms, rd_data);
        press_sb.set_reg(REG_LONG_PRESS, long_press_ms);
        apb_access(1'b0, REG_DEBOUNCE, '0, rd_data);
        if (rd_data[15:0] !== debounce_ms) begin
            $error("debounce_ms readback: expected %0d, actual %0d", debounce_ms, rd_data[15:0]);
            reg_errors++;
        end
        apb_access(1'b0, REG_LONG_PRESS, '0, rd_data);
        if (rd_data[15:0] !== long_press_ms) begin
            $error("long_press_ms readback: expected %0d, actual %0d", long_press_ms,
                   rd_data[15:0]);
            reg_errors++;
        end
        n_settings++;
    endtask

    // One press with bounces on both edges; the timestamp jumps now and then
    task automatic press_cycle(input int unsigned debounce_ms, input int unsigned span);
        repeat ($urandom_range(0, 3)) send_after(1'b1, debounce_ms);
        repeat ($urandom_range(0, 2)) begin
            send_after(1'b0, debounce_ms / 2);
            send_after(1'b1, debounce_ms / 2);
        end
        repeat ($urandom_range(2, 8)) begin
            if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
            send_after(1'b0, span / 2);
        end
        repeat ($urandom_range(0, 2)) begin
            send_after(1'b1, debounce_ms / 2);
            send_after(1'b0, debounce_ms / 2);
        end
        repeat ($urandom_range(1, 5)) send_after(1'b1, debounce_ms);
    endtask

    task automatic run_setting(input logic [15:0] debounce_ms, input logic [15:0] long_press_ms,
                               input int unsigned n_words);
        int unsigned start_cnt;
        int unsigned span;
        set_cfg(debounce_ms, long_press_ms);
        span      = debounce_ms + long_press_ms + 1;
        start_cnt = n_sent;
        clock_ms  = ($urandom_range(0, 1) == 0) ? $urandom
                                                : 32'hFFFF_FFFF - $urandom_range(0, 4 * span);
        while (n_sent - start_cnt < n_words) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: arbitrary levels and timestamps
                repeat ($urandom_range(1, 4)) begin
                    clock_ms = $urandom;
                    send_sample(1'($urandom_range(0, 1)), clock_ms);
                end
            end else begin
                press_cycle(32'(debounce_ms), span);
            end
            if ($urandom_range(0, 11) == 0) drain();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, debounce 10 ms, long press 1000 ms
        send_sample(1'b1, 32'd0);
        send_sample(1'b0, 32'd100);
        send_sample(1'b1, 32'd105);          // press bounce back to idle
        send_sample(1'b0, 32'd110);
        send_sample(1'b0, 32'd119);          // one short of debounce
        send_sample(1'b0, 32'd120);          // debounce met exactly
        send_sample(1'b1, 32'd500);
        send_sample(1'b0, 32'd505);          // release bounce, resumes held
        send_sample(1'b1, 32'd600);
        send_sample(1'b1, 32'd610);          // short press
        send_sample(1'b0, 32'hFFFF_FFF0);
        send_sample(1'b0, 32'h0000_0000);    // debounce across the wrap
        send_sample(1'b0, 32'd999);
        send_sample(1'b0, 32'd1000);         // long limit met exactly
        send_sample(1'b1, 32'd1500);
        send_sample(1'b0, 32'd1502);         // release bounce, resumes long held
        send_sample(1'b1, 32'd1510);
        send_sample(1'b1, 32'd1520);         // long press
        send_sample(1'b0, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'h0000_0010);
        send_sample(1'b1, 32'h0000_0005);    // time goes backwards
        send_sample(1'b1, 32'h0000_0004);

        // Directed: zero debounce and zero limit
        set_cfg(16'd0, 16'd0);
        send_sample(1'b0, 32'd7);
        send_sample(1'b0, 32'd7);
        send_sample(1'b1, 32'd7);
        send_sample(1'b1, 32'd7);

        // Random press traffic over several settings
        run_setting(16'd3, 16'd40, 160);
        run_setting(16'd0, 16'd25, 140);
        run_setting(16'hFFFF, 16'hFFFF, 140);
        run_setting(16'd1, 16'd0, 140);
        run_setting(16'd0, 16'hFFFF, 120);
        run_setting(16'hFFFF, 16'd0, 120);
        run_setting(16'($urandom_range(0, 30)), 16'($urandom_range(0, 200)), 160);
        run_setting(16'($urandom_range(0, 8)), 16'($urandom_range(0, 60)), 120);
        run_setting(16'($urandom), 16'($urandom), 100);

        drain();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d sample words under %0d register settings.", n_sent, n_settings);
        $display("Checked %0d press events: %0d short, %0d long.",
                 press_sb.n_checked, press_sb.n_short, press_sb.n_long);
        if (press_sb.n_errors == 0 && reg_errors == 0 && press_sb.pending() == 0) begin
            $display("** button_debounce_long_press_core: PASSED **");
        end else begin
            $display("** button_debounce_long_press_core: FAILED **");
        end
        $finish;
    end

endmodule
